@@ rtl/core/pie_pkg.sv @@
// Package for the priority inheritance engine.
// Holds field widths, request codes, sequencer states and the table entry type.
// No dependencies.
`timescale 1ns / 1ps

package pie_pkg;

  localparam int unsigned TASKS_DEF   = 16;
  localparam int unsigned REQ_W       = 3;
  localparam int unsigned ID_W        = 5;
  localparam int unsigned LVL_W       = 8;
  localparam int unsigned EFF_W       = 9;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [EFF_W-1:0] EFF_NONE = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET_BASE      = 3'd0,
    REQ_NOTE_WAITER   = 3'd1,
    REQ_CLEAR_BLOCKED = 3'd2,
    REQ_RECOMPUTE     = 3'd3,
    REQ_QUERY         = 3'd4
  } pie_req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TASK_RD,
    ST_CHAIN,
    ST_SCAN,
    ST_SCAN_WR,
    ST_DONE
  } pie_state_e;

  typedef struct packed {
    logic [ID_W-1:0]  blk;
    logic [LVL_W-1:0] eff;
    logic [LVL_W-1:0] base;
  } pie_entry_t;

endpackage

@@ rtl/core/pie_mem.sv @@
// Task table: one synchronous memory with one read and one write port.
// Per-entry valid bits give the all-zero reset; same-cycle write data is forwarded.
// Depends on pie_pkg.
`timescale 1ns / 1ps

module pie_mem #(
  parameter  int unsigned TASKS = pie_pkg::TASKS_DEF,
  localparam int unsigned IdxW  = $clog2(TASKS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [IdxW-1:0]     rd_addr_i,
  output pie_pkg::pie_entry_t rd_data_o,
  input  logic                wr_en_i,
  input  logic [IdxW-1:0]     wr_addr_i,
  input  pie_pkg::pie_entry_t wr_data_i
);
  import pie_pkg::*;

  pie_entry_t       mem_q [TASKS];
  logic [TASKS-1:0] vld_q;
  pie_entry_t       rd_q;
  pie_entry_t       fwd_q;
  logic             rd_vld_q;
  logic             fwd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q  <= mem_q[rd_addr_i];
      fwd_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q  <= vld_q[rd_addr_i];
        fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  assign rd_data_o = fwd_hit_q ? fwd_q : (rd_vld_q ? rd_q : '0);

endmodule

@@ rtl/core/priority_inheritance_engine.sv @@
// Priority inheritance engine: base, effective and blocked-on tables per task.
// Rejected requests go straight to the result; query and clear blocked read the task entry,
// note waiter with a valid owner then walks 1 to TASKS chain steps (one per cycle),
// set base and recompute scan the whole table (one table entry scanned per cycle).
// One request at a time; the next request transfers at the earliest result transfer edge.
// Reset clears all tables at once through per-entry valid bits.
`timescale 1ns / 1ps

module priority_inheritance_engine #(
  parameter int unsigned TASKS = pie_pkg::TASKS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // req_type[2:0], task_id[7:3], owner_id[12:8], base_level[20:13], zero[23:21]
  input  logic [pie_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // eff_level[8:0], applied[9], zero[15:10]
  output logic [pie_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import pie_pkg::*;

  localparam int unsigned IdxW = $clog2(TASKS);

  function automatic logic id_ok(logic [ID_W-1:0] id);
    return !id[ID_W-1] && (32'(id[ID_W-2:0]) < TASKS);
  endfunction

  function automatic logic [IdxW-1:0] id_idx(logic [ID_W-1:0] id);
    return IdxW'(id[ID_W-2:0]);
  endfunction

  pie_state_e        state_q, state_d;
  logic [REQ_W-1:0]  req_q, req_d;
  logic [ID_W-1:0]   task_q, task_d;
  logic [ID_W-1:0]   owner_q, owner_d;
  logic [LVL_W-1:0]  level_q, level_d;
  logic [LVL_W-1:0]  eff_from_q, eff_from_d;
  logic [IdxW-1:0]   to_q, to_d;
  logic [IdxW-1:0]   step_q, step_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic [LVL_W-1:0]  max_q, max_d;
  logic [LVL_W-1:0]  base_t_q, base_t_d;
  logic [ID_W-1:0]   blk_t_q, blk_t_d;
  logic [EFF_W-1:0]  res_eff_q, res_eff_d;
  logic              res_app_q, res_app_d;
  logic              m_valid_q, m_valid_d;
  logic [EFF_W-1:0]  m_eff_q, m_eff_d;
  logic              m_app_q, m_app_d;

  logic [REQ_W-1:0]  in_req;
  logic [ID_W-1:0]   in_task;
  logic [ID_W-1:0]   in_owner;
  logic [LVL_W-1:0]  in_level;

  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  pie_entry_t        rd_data;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  pie_entry_t        wr_data;

  logic [LVL_W-1:0]  base_sel;
  logic [LVL_W-1:0]  best;
  logic [IdxW-1:0]   link;

  assign in_req   = s_axis_tdata[2:0];
  assign in_task  = s_axis_tdata[7:3];
  assign in_owner = s_axis_tdata[12:8];
  assign in_level = s_axis_tdata[20:13];

  pie_mem #(
    .TASKS(TASKS)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  assign base_sel = (req_q == REQ_SET_BASE) ? level_q : base_t_q;
  assign best     = (max_q > base_sel) ? max_q : base_sel;
  assign link     = IdxW'(rd_data.blk - ID_W'(1));

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    task_d     = task_q;
    owner_d    = owner_q;
    level_d    = level_q;
    eff_from_d = eff_from_q;
    to_d       = to_q;
    step_d     = step_q;
    cnt_d      = cnt_q;
    max_d      = max_q;
    base_t_d   = base_t_q;
    blk_t_d    = blk_t_q;
    res_eff_d  = res_eff_q;
    res_app_d  = res_app_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_eff_d    = m_eff_q;
    m_app_d    = m_app_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          req_d   = in_req;
          task_d  = in_task;
          owner_d = in_owner;
          level_d = in_level;
          if (in_req > REQ_QUERY || !id_ok(in_task)) begin
            res_eff_d = EFF_NONE;
            res_app_d = 1'b0;
            state_d   = ST_DONE;
          end else if (in_req == REQ_SET_BASE || in_req == REQ_RECOMPUTE) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            cnt_d   = '0;
            max_d   = '0;
            state_d = ST_SCAN;
          end else begin
            rd_en   = 1'b1;
            rd_addr = id_idx(in_task);
            state_d = ST_TASK_RD;
          end
        end
      end
      ST_TASK_RD: begin
        res_eff_d  = {1'b0, rd_data.eff};
        res_app_d  = 1'b1;
        eff_from_d = rd_data.eff;
        state_d    = ST_DONE;
        if (req_q == REQ_CLEAR_BLOCKED) begin
          wr_en       = 1'b1;
          wr_addr     = id_idx(task_q);
          wr_data     = rd_data;
          wr_data.blk = '0;
        end else if (req_q == REQ_NOTE_WAITER) begin
          if (id_ok(owner_q)) begin
            wr_en       = 1'b1;
            wr_addr     = id_idx(task_q);
            wr_data     = rd_data;
            wr_data.blk = {1'b0, owner_q[ID_W-2:0]} + ID_W'(1);
            rd_en       = 1'b1;
            rd_addr     = id_idx(owner_q);
            to_d        = id_idx(owner_q);
            step_d      = '0;
            state_d     = ST_CHAIN;
          end else begin
            res_app_d = 1'b0;
          end
        end
      end
      ST_CHAIN: begin
        if (rd_data.eff >= eff_from_q) begin
          state_d = ST_DONE;
        end else begin
          wr_en       = 1'b1;
          wr_addr     = to_q;
          wr_data     = rd_data;
          wr_data.eff = eff_from_q;
          if (rd_data.blk == '0 || 32'(rd_data.blk) > TASKS ||
              step_q == IdxW'(TASKS - 1)) begin
            state_d = ST_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = link;
            to_d    = link;
            step_d  = step_q + IdxW'(1);
          end
        end
      end
      ST_SCAN: begin
        if (rd_data.blk == ({1'b0, task_q[ID_W-2:0]} + ID_W'(1)) && rd_data.eff > max_q) begin
          max_d = rd_data.eff;
        end
        if (cnt_q == id_idx(task_q)) begin
          base_t_d = rd_data.base;
          blk_t_d  = rd_data.blk;
        end
        if (cnt_q == IdxW'(TASKS - 1)) begin
          state_d = ST_SCAN_WR;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cnt_q + IdxW'(1);
          cnt_d   = cnt_q + IdxW'(1);
        end
      end
      ST_SCAN_WR: begin
        wr_en     = 1'b1;
        wr_addr   = id_idx(task_q);
        wr_data   = '{blk: blk_t_q, eff: best, base: base_sel};
        res_eff_d = {1'b0, best};
        res_app_d = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_eff_d   = res_eff_q;
          m_app_d   = res_app_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    task_q     <= task_d;
    owner_q    <= owner_d;
    level_q    <= level_d;
    eff_from_q <= eff_from_d;
    to_q       <= to_d;
    step_q     <= step_d;
    cnt_q      <= cnt_d;
    max_q      <= max_d;
    base_t_q   <= base_t_d;
    blk_t_q    <= blk_t_d;
    res_eff_q  <= res_eff_d;
    res_app_q  <= res_app_d;
    m_eff_q    <= m_eff_d;
    m_app_q    <= m_app_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - EFF_W - 1){1'b0}}, m_app_q, m_eff_q};

endmodule

@@ rtl/core/pie_chk.sv @@
// Port-level checker for the priority inheritance engine, with its bind.
// Depends on pie_pkg and priority_inheritance_engine.
`timescale 1ns / 1ps

module pie_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [pie_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import pie_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is in progress");

  a_none_not_applied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[EFF_W-1:0] == EFF_NONE |-> !m_axis_tdata[EFF_W])
    else $error("invalid-task result marked applied");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:EFF_W+1] == '0)
    else $error("result padding bits not zero");

endmodule

bind priority_inheritance_engine pie_chk u_pie_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

@@ tb/pie_inherit_checker.sv @@
`timescale 1ns / 1ps
// Checker for the priority inheritance engine: tracks its own copy of the three
// task tables, derives the owed result of every request transfer and compares results.
// Depends on pie_pkg.

module pie_inherit_checker #(
  parameter int unsigned TASKS = pie_pkg::TASKS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [pie_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [pie_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  output int                              fail_o,
  output int                              owed_o,
  output int                              results_o,
  output int                              walk_o
);
  import pie_pkg::*;

  localparam int unsigned TID_LO = REQ_W;
  localparam int unsigned OWN_LO = REQ_W + ID_W;
  localparam int unsigned LVL_LO = REQ_W + 2 * ID_W;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [EFF_W-1:0] level;
    logic             applied;
  } prio_result_t;

  logic [LVL_W-1:0] base_tbl   [TASKS];
  logic [LVL_W-1:0] eff_tbl    [TASKS];
  logic [ID_W-1:0]  holder_tbl [TASKS];

  prio_result_t owed_results[$];
  prio_result_t want;
  prio_result_t got;
  int           faults = 0;
  int           seen = 0;
  int           longest = 0;
  int           idx;

  function automatic logic [LVL_W-1:0] inherited_level(int t);
    logic [LVL_W-1:0] best;
    int               p;
    best = base_tbl[t];
    for (p = 0; p < TASKS; p++) begin
      if (holder_tbl[p] == t + 1 && eff_tbl[p] > best) best = eff_tbl[p];
    end
    return best;
  endfunction

  function automatic prio_result_t resolve_request(logic [REQ_W-1:0] code,
                                                   logic signed [ID_W-1:0] tid,
                                                   logic signed [ID_W-1:0] oid,
                                                   logic [LVL_W-1:0] lvl);
    prio_result_t res;
    int           t;
    int           o;
    int           from;
    int           to;
    int           walk;
    int           step;
    t = tid;
    o = oid;
    res.level   = EFF_NONE;
    res.applied = 1'b0;
    if (code > REQ_QUERY || t < 0 || t >= TASKS) return res;
    res.applied = 1'b1;
    case (code)
      REQ_SET_BASE: begin
        base_tbl[t] = lvl;
        eff_tbl[t]  = inherited_level(t);
      end
      REQ_NOTE_WAITER: begin
        if (o >= 0 && o < TASKS) begin
          holder_tbl[t] = ID_W'(o + 1);
          from = t;
          to   = o;
          walk = 0;
          for (step = 0; step < TASKS; step++) begin
            if (eff_tbl[to] >= eff_tbl[from]) break;
            eff_tbl[to] = eff_tbl[from];
            walk++;
            if (holder_tbl[to] == '0) break;
            from = to;
            to   = int'(holder_tbl[to]) - 1;
            if (to < 0 || to >= TASKS) break;
          end
          if (walk > longest) longest = walk;
        end else begin
          res.applied = 1'b0;
        end
      end
      REQ_CLEAR_BLOCKED: holder_tbl[t] = '0;
      REQ_RECOMPUTE:     eff_tbl[t] = inherited_level(t);
      default: ;
    endcase
    res.level = {1'b0, eff_tbl[t]};
    return res;
  endfunction

  task automatic log_fault(string what, prio_result_t exp_r, prio_result_t act_r);
    faults++;
    if (faults <= REPORT_MAX) begin
      $display("%0t ERROR %s: expected eff_level %0d applied %0b, got eff_level %0d applied %0b",
               $time, what, $signed(exp_r.level), exp_r.applied,
               $signed(act_r.level), act_r.applied);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (idx = 0; idx < TASKS; idx++) begin
        base_tbl[idx]   = '0;
        eff_tbl[idx]    = '0;
        holder_tbl[idx] = '0;
      end
      owed_results.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        owed_results.push_back(resolve_request(s_tdata_i[TID_LO-1:0],
                                               s_tdata_i[OWN_LO-1:TID_LO],
                                               s_tdata_i[LVL_LO-1:OWN_LO],
                                               s_tdata_i[LVL_LO+LVL_W-1:LVL_LO]));
      end
      if (m_tvalid_i && m_tready_i) begin
        seen++;
        got.level   = m_tdata_i[EFF_W-1:0];
        got.applied = m_tdata_i[EFF_W];
        if (owed_results.size() == 0) begin
          want.level   = EFF_NONE;
          want.applied = 1'b0;
          log_fault("result with no request outstanding", want, got);
        end else begin
          want = owed_results.pop_front();
          if (want !== got) log_fault("result mismatch", want, got);
        end
      end
    end
    fail_o    <= faults;
    owed_o    <= owed_results.size();
    results_o <= seen;
    walk_o    <= longest;
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Top of the priority inheritance engine testbench: clock, reset, request stimulus
// with random idling on both streams, watchdog and verdict.
// Depends on pie_pkg, priority_inheritance_engine and pie_inherit_checker.

module testbench;
  import pie_pkg::*;

  localparam int unsigned TASKS = TASKS_DEF;
  localparam int unsigned PAD_W = IN_TDATA_W - REQ_W - 2 * ID_W - LVL_W;
  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_FIRST = 200;
  localparam int CALM_LAST = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * TASKS + 8;
  localparam int IDLE_PCT = 15;

  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
  localparam logic [ID_W-1:0]  NO_TASK = '1;
  localparam logic [ID_W-1:0]  ID_MOST_NEG = {1'b1, {(ID_W-1){1'b0}}};
  localparam logic [LVL_W-1:0] LVL_MAX = '1;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int fail_cnt;
  int owed_cnt;
  int result_cnt;
  int walk_max;
  int quiet = 0;
  int op_count[8] = '{default: 0};
  bit calm = 1'b0;

  logic [IN_TDATA_W-1:0] plan_q[$];

  priority_inheritance_engine #(.TASKS(TASKS)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pie_inherit_checker #(.TASKS(TASKS)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .fail_o     (fail_cnt),
    .owed_o     (owed_cnt),
    .results_o  (result_cnt),
    .walk_o     (walk_max)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet <= 0;
      end else if (quiet + 1 >= STALL_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("priority_inheritance_engine verification failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_req(logic [REQ_W-1:0] code,
                                                     logic [ID_W-1:0] tid,
                                                     logic [ID_W-1:0] oid,
                                                     logic [LVL_W-1:0] lvl);
    return {{PAD_W{1'b0}}, lvl, oid, tid, code};
  endfunction

  function automatic logic [ID_W-1:0] hot_task();
    return $urandom_range(0, 1) ? ID_W'($urandom_range(0, 5))
                                : ID_W'($urandom_range(0, TASKS - 1));
  endfunction

  function automatic logic [LVL_W-1:0] pick_level();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? LVL_MAX : '0;
    return LVL_W'($urandom_range(0, 255));
  endfunction

  task automatic send_req(logic [IN_TDATA_W-1:0] word);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    op_count[word[REQ_W-1:0]]++;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Build the edges from the far end first, then donate from the head.
  task automatic queue_chain(int len);
    int s;
    int k;
    s = $urandom_range(0, TASKS - 1);
    for (k = len - 2; k >= 1; k--) begin
      plan_q.push_back(pack_req(REQ_NOTE_WAITER, ID_W'((s + k) % TASKS),
                                ID_W'((s + k + 1) % TASKS), pick_level()));
    end
    plan_q.push_back(pack_req(REQ_SET_BASE, ID_W'(s), hot_task(),
                              LVL_W'($urandom_range(128, 255))));
    plan_q.push_back(pack_req(REQ_NOTE_WAITER, ID_W'(s), ID_W'((s + 1) % TASKS),
                              pick_level()));
  endtask

  task automatic plan_random();
    int               r;
    int               k;
    logic [REQ_W-1:0] code;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      plan_q.push_back(pack_req(REQ_W'($urandom_range(0, 7)), ID_W'($urandom_range(0, 31)),
                                ID_W'($urandom_range(0, 31)), LVL_W'($urandom_range(0, 255))));
    end else if (r < 12) begin
      case ($urandom_range(0, 2))
        0: plan_q.push_back(pack_req(REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)),
                                     hot_task(), hot_task(), pick_level()));
        1: plan_q.push_back(pack_req(REQ_NOTE_WAITER, hot_task(),
                                     ID_W'($urandom_range(16, 31)), pick_level()));
        default: plan_q.push_back(pack_req(REQ_W'($urandom_range(REQ_SET_BASE, REQ_QUERY)),
                                           ID_W'($urandom_range(16, 31)), hot_task(),
                                           pick_level()));
      endcase
    end else if (r < 18) begin
      queue_chain(($urandom_range(0, 7) == 0) ? TASKS : $urandom_range(3, 8));
    end else begin
      k = $urandom_range(0, 99);
      if (k < 25) code = REQ_SET_BASE;
      else if (k < 55) code = REQ_NOTE_WAITER;
      else if (k < 70) code = REQ_CLEAR_BLOCKED;
      else if (k < 85) code = REQ_RECOMPUTE;
      else code = REQ_QUERY;
      plan_q.push_back(pack_req(code, hot_task(), hot_task(), pick_level()));
    end
  endtask

  initial begin
    int c;
    int n;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_req(pack_req(REQ_QUERY, 0, NO_TASK, '0));
    send_req(pack_req(REQ_SET_BASE, 0, 0, LVL_MAX));
    send_req(pack_req(REQ_QUERY, NO_TASK, 0, '0));
    send_req(pack_req(REQ_SET_BASE, ID_MOST_NEG, 0, LVL_MAX));
    for (c = REQ_UNUSED_LO; c <= REQ_UNUSED_HI; c++) begin
      send_req(pack_req(REQ_W'(c), 2, 3, 8'h5A));
    end
    send_req(pack_req(REQ_NOTE_WAITER, 0, NO_TASK, '0));
    send_req(pack_req(REQ_NOTE_WAITER, 0, ID_MOST_NEG, '0));
    send_req(pack_req(REQ_NOTE_WAITER, 1, 0, '0));
    send_req(pack_req(REQ_SET_BASE, 2, 0, 8'd100));
    send_req(pack_req(REQ_NOTE_WAITER, 2, 2, '0));
    send_req(pack_req(REQ_SET_BASE, 7, 0, 8'd5));
    send_req(pack_req(REQ_NOTE_WAITER, 6, 7, '0));
    send_req(pack_req(REQ_SET_BASE, 5, 0, 8'd200));
    send_req(pack_req(REQ_NOTE_WAITER, 5, 6, '0));
    send_req(pack_req(REQ_QUERY, 7, 0, '0));
    send_req(pack_req(REQ_CLEAR_BLOCKED, 5, 0, '0));
    send_req(pack_req(REQ_RECOMPUTE, 6, 0, '0));
    send_req(pack_req(REQ_RECOMPUTE, 7, 0, '0));
    send_req(pack_req(REQ_RECOMPUTE, 5'b11000, 0, '0));
    send_req(pack_req(REQ_CLEAR_BLOCKED, ID_MOST_NEG, 0, '0));
    send_req(pack_req(REQ_SET_BASE, 15, 0, 8'hAA));
    send_req(pack_req(REQ_SET_BASE, 14, 0, 8'h55));
    send_req(pack_req(REQ_NOTE_WAITER, 14, 15, '0));

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      if (plan_q.size() == 0) plan_random();
      send_req(plan_q.pop_front());
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (owed_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Requests: %0d set base, %0d note waiter, %0d clear blocked, %0d recompute, %0d query",
             op_count[REQ_SET_BASE], op_count[REQ_NOTE_WAITER], op_count[REQ_CLEAR_BLOCKED],
             op_count[REQ_RECOMPUTE], op_count[REQ_QUERY]);
    $display("Unused codes %0d; %0d results checked; longest donation walk %0d steps",
             op_count[5] + op_count[6] + op_count[7], result_cnt, walk_max);
    if (fail_cnt == 0 && owed_cnt == 0) begin
      $display("priority_inheritance_engine verification clean");
    end else begin
      $display("priority_inheritance_engine verification failed");
    end
    $finish;
  end

endmodule
